[src/rpf_pkg.sv]
// ----------------------------------------------------------------------------
// rpf_pkg: shared constants and types for the pair repulsive force pipeline
// Fixed-point formats, stage counts and the sideband record that travels
// alongside the arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none

package rpf_pkg;

  // Fraction bits of every fixed-point quantity.
  localparam int POS_FRAC_BITS = 24;

  localparam longint ONE_RAW   = longint'(1) << POS_FRAC_BITS;
  // Cutoff radius of 0.01 and minimum radius of cutoff/100, rounded.
  localparam longint CUT_RAW   = (ONE_RAW + 50) / 100;
  localparam longint MINR_RAW  = (ONE_RAW + 5000) / 10000;
  localparam longint CUT2_RAW  = CUT_RAW * CUT_RAW;
  localparam longint MINR2_RAW = MINR_RAW * MINR_RAW;

  // Dividing by the mass of 1/100 is a multiplication by 100.
  localparam int FORCE_SCALE = 100;
  localparam int SCALE_W     = 7;

  localparam int POS_W  = 32;
  localparam int ACC_W  = 64;
  localparam int DIFF_W = POS_W + 1;

  // Width of a distance component that lies within the cutoff.
  localparam int CUT_W    = $clog2(CUT_RAW + 1);
  // Floor of log2 of the minimum radius; bounds the quotients.
  localparam int MINR_LOG = $clog2(MINR_RAW + 1) - 1;

  localparam int R2_W       = 2 * CUT_W;
  localparam int SQRT_STEPS = CUT_W;
  localparam int SQ_REM_W   = CUT_W + 2;

  localparam int DIV_NUM_W = 2 * POS_FRAC_BITS + 1;
  localparam int DIV_Q_W   = DIV_NUM_W - MINR_LOG;
  localparam int DIV_D_W   = CUT_W;

  localparam int U_W   = POS_FRAC_BITS + 1;
  localparam int G_W   = CUT_W + POS_FRAC_BITS - MINR_LOG;
  localparam int VHI_W = DIV_Q_W - POS_FRAC_BITS;
  localparam int PH_W  = G_W + VHI_W;
  localparam int PL_W  = G_W + POS_FRAC_BITS;
  localparam int W_W   = PH_W + 1;
  localparam int M_W   = W_W + SCALE_W;

  // Front end, square root, two divider passes, multiply, sum, scale, output.
  localparam int FRONT_STAGES = 3;
  localparam int BACK_STAGES  = 4;
  localparam int LATENCY      = FRONT_STAGES + SQRT_STEPS + 2 * DIV_Q_W + BACK_STAGES;

  typedef struct packed {
    logic signed [ACC_W-1:0] ax;
    logic signed [ACC_W-1:0] ay;
    logic                    in_range;
    logic                    dx_neg;
    logic                    dx_zero;
    logic                    dy_neg;
    logic                    dy_zero;
    logic [CUT_W-1:0]        adx;
    logic [CUT_W-1:0]        ady;
    logic [CUT_W-1:0]        r;
    logic [G_W-1:0]          g;
  } side_t;

endpackage

`default_nettype wire

[src/rpf_in_if.sv]
// ----------------------------------------------------------------------------
// rpf_in_if: input channel of the pair force pipeline
// Carries both positions and the running acceleration of one pair.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpf_in_if;
  import rpf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] self_x;
  logic signed [POS_W-1:0] self_y;
  logic signed [POS_W-1:0] other_x;
  logic signed [POS_W-1:0] other_y;
  logic signed [ACC_W-1:0] accel_x_in;
  logic signed [ACC_W-1:0] accel_y_in;

  modport source (output valid, self_x, self_y, other_x, other_y, accel_x_in, accel_y_in,
                  input ready);
  modport sink (input valid, self_x, self_y, other_x, other_y, accel_x_in, accel_y_in,
                output ready);
endinterface

`default_nettype wire

[src/rpf_out_if.sv]
// ----------------------------------------------------------------------------
// rpf_out_if: result channel of the pair force pipeline
// Carries the updated acceleration and the status flags of one pair.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpf_out_if;
  import rpf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] accel_x_out;
  logic signed [ACC_W-1:0] accel_y_out;
  logic                    within_cutoff;
  logic                    saturated;

  modport source (output valid, accel_x_out, accel_y_out, within_cutoff, saturated,
                  input ready);
  modport sink (input valid, accel_x_out, accel_y_out, within_cutoff, saturated,
                output ready);
endinterface

`default_nettype wire

[src/rpf_sqrt.sv]
// ----------------------------------------------------------------------------
// rpf_sqrt: pipelined integer square root
// Restoring digit-by-digit root, one result bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rpf_sqrt (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [rpf_pkg::R2_W-1:0]  x,
  output      logic [rpf_pkg::CUT_W-1:0] root
);
  import rpf_pkg::*;

  logic [SQ_REM_W-1:0] rem_q  [SQRT_STEPS];
  logic [CUT_W-1:0]    root_q [SQRT_STEPS];
  logic [R2_W-1:0]     x_q    [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [SQ_REM_W-1:0] rem_in;
    logic [CUT_W-1:0]    root_in;
    logic [R2_W-1:0]     x_in;
    logic [SQ_REM_W+1:0] t;
    logic [SQ_REM_W+1:0] trial;
    logic                ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x;
    end else begin : g_rest
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in    = x_q[k-1];
    end

    assign t     = {rem_in, x_in[R2_W-1 -: 2]};
    assign trial = (SQ_REM_W + 2)'({root_in, 2'b01});
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? SQ_REM_W'(t - trial) : t[SQ_REM_W-1:0];
        root_q[k] <= {root_in[CUT_W-2:0], ge};
        x_q[k]    <= x_in << 2;
      end
    end
  end

  assign root = root_q[SQRT_STEPS-1];

endmodule

`default_nettype wire

[src/rpf_div.sv]
// ----------------------------------------------------------------------------
// rpf_div: pipelined unsigned divider
// Restoring long division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rpf_div (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [rpf_pkg::DIV_NUM_W-1:0] num,
  input  wire logic [rpf_pkg::DIV_D_W-1:0]   den,
  output      logic [rpf_pkg::DIV_Q_W-1:0]   quo
);
  import rpf_pkg::*;

  // The numerator bits above the quotient are always below the divisor.
  localparam int HEAD_W = DIV_NUM_W - DIV_Q_W;

  logic [DIV_D_W-1:0] rem_q [DIV_Q_W];
  logic [DIV_Q_W-1:0] lo_q  [DIV_Q_W];
  logic [DIV_D_W-1:0] den_q [DIV_Q_W];
  logic [DIV_Q_W-1:0] quo_q [DIV_Q_W];

  for (genvar k = 0; k < DIV_Q_W; k++) begin : g_step
    logic [DIV_D_W-1:0] rem_in;
    logic [DIV_Q_W-1:0] lo_in;
    logic [DIV_D_W-1:0] den_in;
    logic [DIV_Q_W-1:0] quo_in;
    logic [DIV_D_W:0]   t;
    logic               ge;

    if (k == 0) begin : g_first
      assign rem_in = DIV_D_W'(num[DIV_NUM_W-1 -: HEAD_W]);
      assign lo_in  = num[DIV_Q_W-1:0];
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign t  = {rem_in, lo_in[DIV_Q_W-1]};
    assign ge = (t >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? DIV_D_W'(t - {1'b0, den_in}) : t[DIV_D_W-1:0];
        lo_q[k]  <= lo_in << 1;
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[DIV_Q_W-2:0], ge};
      end
    end
  end

  assign quo = quo_q[DIV_Q_W-1];

endmodule

`default_nettype wire

[src/pair_repulsive_force.sv]
// ----------------------------------------------------------------------------
// pair_repulsive_force: short-range repulsive force of one neighbour pair
// Adds the cutoff repulsion of a neighbour to a particle's acceleration.
// ----------------------------------------------------------------------------
// Usage. Each beat on the pair channel carries both positions (Q8.24) and the
// running acceleration (Q40.24) of the particle acted on. Each beat on the
// result channel carries the updated, saturated acceleration, a flag that
// tells whether the neighbour lay inside the cutoff, and a flag that tells
// whether either sum was clipped. Results leave in the order pairs entered,
// one result per pair.
// Throughput is one pair per clock cycle unless the receiver stalls. The
// pipeline has three front-end stages, one stage per root bit in the
// square root, one stage per quotient bit in each of the two divider passes,
// then multiply, sum, scale and the output register.
// The whole pipeline advances on one enable: it moves whenever the output
// register is empty or its beat is being taken. When the receiver stalls
// with a result waiting, every stage holds and the pair channel drops ready,
// so nothing is lost or repeated.
// Synchronous reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_repulsive_force (
  input  wire logic clk,
  input  wire logic rst,
  rpf_in_if.sink    pair,
  rpf_out_if.source result
);
  import rpf_pkg::*;

  // One valid bit per stage; the last one is the output register's.
  logic [LATENCY-1:0] valid_pipe;
  logic               en;
  logic               take;

  assign en         = !valid_pipe[LATENCY-1] || result.ready;
  assign pair.ready = en;
  assign take       = pair.valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else if (en) begin
      valid_pipe <= {valid_pipe[LATENCY-2:0], take};
    end
  end

  // ---------------------------------------------------------------- front end
  // Stage 1: component differences, their magnitudes and the coarse range test.
  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0]        adx, ady;
  side_t                    s1_side_next, s1_side;
  logic                     s1_far;

  assign dx  = DIFF_W'(pair.other_x) - DIFF_W'(pair.self_x);
  assign dy  = DIFF_W'(pair.other_y) - DIFF_W'(pair.self_y);
  assign adx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign ady = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

  always_comb begin
    s1_side_next         = '0;
    s1_side_next.ax      = pair.accel_x_in;
    s1_side_next.ay      = pair.accel_y_in;
    s1_side_next.dx_neg  = dx[DIFF_W-1];
    s1_side_next.dx_zero = (dx == '0);
    s1_side_next.dy_neg  = dy[DIFF_W-1];
    s1_side_next.dy_zero = (dy == '0);
    s1_side_next.adx     = adx[CUT_W-1:0];
    s1_side_next.ady     = ady[CUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side <= s1_side_next;
      s1_far  <= (adx > DIFF_W'(CUT_RAW)) || (ady > DIFF_W'(CUT_RAW));
    end
  end

  // Stage 2: squares of the component magnitudes.
  side_t           s2_side;
  logic            s2_far;
  logic [R2_W-1:0] sqx, sqy;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side <= s1_side;
      s2_far  <= s1_far;
      sqx     <= R2_W'(s1_side.adx) * R2_W'(s1_side.adx);
      sqy     <= R2_W'(s1_side.ady) * R2_W'(s1_side.ady);
    end
  end

  // Stage 3: squared distance, cutoff test and the clamp to the minimum radius.
  logic [R2_W:0]   r2_sum;
  logic [R2_W-1:0] s3_r2;
  side_t           s3_side_next, s3_side;

  assign r2_sum = (R2_W + 1)'(sqx) + (R2_W + 1)'(sqy);

  always_comb begin
    s3_side_next          = s2_side;
    s3_side_next.in_range = !s2_far && (r2_sum <= (R2_W + 1)'(CUT2_RAW));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side <= s3_side_next;
      s3_r2   <= (r2_sum < (R2_W + 1)'(MINR2_RAW)) ? R2_W'(MINR2_RAW) : r2_sum[R2_W-1:0];
    end
  end

  // -------------------------------------------------------------- square root
  logic [CUT_W-1:0] r_root;
  side_t            sq_side [SQRT_STEPS];

  rpf_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .x    (s3_r2),
    .root (r_root)
  );

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq_side
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          sq_side[k] <= s3_side;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          sq_side[k] <= sq_side[k-1];
        end
      end
    end
  end

  // ------------------------------------------------------ first divider pass
  // g = (cutoff - r) / r and u = |d| / r for both components, in parallel.
  side_t                d1_side_in;
  logic [DIV_NUM_W-1:0] g_num, ux_num, uy_num;
  logic [DIV_Q_W-1:0]   g_quo, ux_quo, uy_quo;
  side_t                d1_side [DIV_Q_W];

  always_comb begin
    d1_side_in   = sq_side[SQRT_STEPS-1];
    d1_side_in.r = r_root;
  end

  assign g_num  = DIV_NUM_W'(CUT_W'(CUT_RAW) - r_root) << POS_FRAC_BITS;
  assign ux_num = DIV_NUM_W'(d1_side_in.adx) << POS_FRAC_BITS;
  assign uy_num = DIV_NUM_W'(d1_side_in.ady) << POS_FRAC_BITS;

  rpf_div u_div_g (.clk(clk), .en(en), .num(g_num),  .den(r_root), .quo(g_quo));
  rpf_div u_div_ux (.clk(clk), .en(en), .num(ux_num), .den(r_root), .quo(ux_quo));
  rpf_div u_div_uy (.clk(clk), .en(en), .num(uy_num), .den(r_root), .quo(uy_quo));

  for (genvar k = 0; k < DIV_Q_W; k++) begin : g_d1_side
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          d1_side[k] <= d1_side_in;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          d1_side[k] <= d1_side[k-1];
        end
      end
    end
  end

  // ----------------------------------------------------- second divider pass
  // v = u / r, giving |d| / r^2 for each component.
  side_t                d2_side_in;
  logic [DIV_NUM_W-1:0] vx_num, vy_num;
  logic [DIV_Q_W-1:0]   vx, vy;
  side_t                d2_side [DIV_Q_W];

  always_comb begin
    d2_side_in   = d1_side[DIV_Q_W-1];
    d2_side_in.g = g_quo[G_W-1:0];
  end

  assign vx_num = DIV_NUM_W'(ux_quo[U_W-1:0]) << POS_FRAC_BITS;
  assign vy_num = DIV_NUM_W'(uy_quo[U_W-1:0]) << POS_FRAC_BITS;

  rpf_div u_div_vx (.clk(clk), .en(en), .num(vx_num), .den(d2_side_in.r), .quo(vx));
  rpf_div u_div_vy (.clk(clk), .en(en), .num(vy_num), .den(d2_side_in.r), .quo(vy));

  for (genvar k = 0; k < DIV_Q_W; k++) begin : g_d2_side
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          d2_side[k] <= d2_side_in;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          d2_side[k] <= d2_side[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- back end
  // g * v is split into the integer and fraction parts of v, so that each
  // multiplier stays narrow; the fraction product is truncated on its own.
  side_t           p1_side, p2_side, p3_side;
  side_t           v_side;
  logic [PH_W-1:0] phx, phy;
  logic [PL_W-1:0] plx, ply;
  logic [W_W-1:0]  wx, wy;
  logic [M_W-1:0]  mx, my;
  logic [ACC_W-1:0] delta_x, delta_y;

  assign v_side = d2_side[DIV_Q_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      p1_side <= v_side;
      phx     <= PH_W'(v_side.g) * PH_W'(vx[DIV_Q_W-1:POS_FRAC_BITS]);
      phy     <= PH_W'(v_side.g) * PH_W'(vy[DIV_Q_W-1:POS_FRAC_BITS]);
      plx     <= PL_W'(v_side.g) * PL_W'(vx[POS_FRAC_BITS-1:0]);
      ply     <= PL_W'(v_side.g) * PL_W'(vy[POS_FRAC_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_side <= p1_side;
      wx      <= W_W'(phx) + W_W'(plx >> POS_FRAC_BITS);
      wy      <= W_W'(phy) + W_W'(ply >> POS_FRAC_BITS);
    end
  end

  assign mx = M_W'(wx) * M_W'(FORCE_SCALE);
  assign my = M_W'(wy) * M_W'(FORCE_SCALE);

  // The force pushes the particle away from its neighbour: a positive
  // component gets the magnitude subtracted, a negative one gets it added.
  always_ff @(posedge clk) begin
    if (en) begin
      p3_side <= p2_side;
      if (!p2_side.in_range || p2_side.dx_zero) begin
        delta_x <= '0;
      end else if (p2_side.dx_neg) begin
        delta_x <= ACC_W'(mx);
      end else begin
        delta_x <= ACC_W'(-ACC_W'(mx));
      end
      if (!p2_side.in_range || p2_side.dy_zero) begin
        delta_y <= '0;
      end else if (p2_side.dy_neg) begin
        delta_y <= ACC_W'(my);
      end else begin
        delta_y <= ACC_W'(-ACC_W'(my));
      end
    end
  end

  // Saturating sums into the output register.
  logic [ACC_W-1:0] sum_x, sum_y;
  logic             ovf_x, ovf_y;
  logic [ACC_W-1:0] acc_x_next, acc_y_next;

  assign sum_x = p3_side.ax + delta_x;
  assign sum_y = p3_side.ay + delta_y;
  assign ovf_x = (p3_side.ax[ACC_W-1] == delta_x[ACC_W-1]) &&
                 (sum_x[ACC_W-1] != p3_side.ax[ACC_W-1]);
  assign ovf_y = (p3_side.ay[ACC_W-1] == delta_y[ACC_W-1]) &&
                 (sum_y[ACC_W-1] != p3_side.ay[ACC_W-1]);

  always_comb begin
    acc_x_next = sum_x;
    if (ovf_x) begin
      acc_x_next = p3_side.ax[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    acc_y_next = sum_y;
    if (ovf_y) begin
      acc_y_next = p3_side.ay[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.accel_x_out   <= acc_x_next;
      result.accel_y_out   <= acc_y_next;
      result.within_cutoff <= p3_side.in_range;
      result.saturated     <= ovf_x || ovf_y;
    end
  end

  assign result.valid = valid_pipe[LATENCY-1];

endmodule

`default_nettype wire

[src/rpf_checker.sv]
// ----------------------------------------------------------------------------
// rpf_checker: port-level checks for the pair repulsive force block
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module rpf_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [rpf_pkg::ACC_W-1:0]       out_accel_x,
  input wire logic                            out_within,
  input wire logic                            out_saturated
);
  import rpf_pkg::*;

  // A result that is not taken stays offered, with its x acceleration unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_accel_x))
    else $error("result beat changed while stalled");

  // The pipeline only holds back pairs while a result waits.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("pair channel stalled with an empty output register");

  // A pair beyond the cutoff adds nothing, so it cannot clip.
  a_far_no_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_within |-> !out_saturated)
    else $error("saturation flagged for a pair beyond the cutoff");

  // Reset empties the whole pipeline.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind pair_repulsive_force rpf_checker u_rpf_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (pair.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .out_accel_x   (result.accel_x_out),
  .out_within    (result.within_cutoff),
  .out_saturated (result.saturated)
);

`default_nettype wire
